// ===== sv/clutch_friction_torque_step_macros.svh =====
// assertion macros for the clutch friction torque step checker
`ifndef CLUTCH_FRICTION_TORQUE_STEP_MACROS_SVH
`define CLUTCH_FRICTION_TORQUE_STEP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CFT_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("clutch step check failed");

// next-cycle implication, disabled while reset is asserted
`define CFT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("clutch step check failed");

`endif

// ===== sv/cft_pkg.sv =====
// types and constants for the clutch friction torque step block
`default_nettype none

package cft_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_MAX_TORQUE  = 3'd0;
    localparam logic [2:0] CFG_ENGAGE_RATE = 3'd1;
    localparam logic [2:0] CFG_STATIC_FRIC = 3'd2;
    localparam logic [2:0] CFG_DYN_FRIC    = 3'd3;
    localparam logic [2:0] CFG_INV_INERTIA = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register reset values
    localparam logic [15:0] RST_MAX_TORQUE  = 16'd8000;
    localparam logic [15:0] RST_ENGAGE_RATE = 16'd512;
    localparam logic [15:0] RST_STATIC_FRIC = 16'd19661;
    localparam logic [15:0] RST_DYN_FRIC    = 16'd16384;
    localparam logic [23:0] RST_INV_INERTIA = 24'd131072;

    localparam logic [16:0] FULL_ENGAGE = 17'h10000;
    localparam logic [16:0] UNIT_SLIP   = 17'h10000;
    localparam logic [32:0] LOCK_WINDOW = 33'd32768;
    localparam logic [32:0] SLIP_LIMIT  = 33'd6553;

    // shared multiplier operand widths
    localparam int MUL_A_W = 39;
    localparam int MUL_B_W = 24;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    typedef struct packed {
        logic [15:0]        time_step;
        logic signed [31:0] shaft_speed_in;
        logic [16:0]        target_engagement;
    } cft_in_t;

    typedef struct packed {
        logic signed [31:0] shaft_speed_out;
        logic signed [31:0] torque;
        logic [16:0]        engagement_now;
        logic               slipping;
    } cft_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_STEP,
        ST_RAMP,
        ST_MUL_DYN,
        ST_COEFF,
        ST_MUL_CAP,
        ST_MUL_TRQ,
        ST_MUL_ACC,
        ST_MUL_CHG,
        ST_FINISH
    } cft_state_t;

    typedef struct packed {
        cft_state_t state;
        logic       load;
        logic       finish;
        logic       mul_en;
    } cft_ctl_t;

endpackage

`default_nettype wire

// ===== sv/cft_mul.sv =====
// shared unsigned multiplier with registered product
`default_nettype none

module cft_mul (
    input  wire logic                         aclk,
    input  wire logic                         en,
    input  wire logic [cft_pkg::MUL_A_W-1:0]  a,
    input  wire logic [cft_pkg::MUL_B_W-1:0]  b,
    output logic      [cft_pkg::MUL_P_W-1:0]  p
);

    logic [cft_pkg::MUL_P_W-1:0] p_reg;
    logic [cft_pkg::MUL_P_W-1:0] p_next;

    assign p_next = cft_pkg::MUL_P_W'(a) * cft_pkg::MUL_P_W'(b);

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ===== sv/cft_seq.sv =====
// sequencer stepping the shared multiplier through one tick
`default_nettype none

module cft_seq (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    input  wire logic         out_free,
    output logic              s_ready,
    output cft_pkg::cft_ctl_t ctl
);

    cft_pkg::cft_state_t state_reg;
    cft_pkg::cft_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cft_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctl.state  = state_reg;
        ctl.load   = 1'b0;
        ctl.finish = 1'b0;
        ctl.mul_en = 1'b0;
        s_ready    = 1'b0;
        unique case (state_reg)
            cft_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                ctl.load = s_valid;
                if (s_valid) begin
                    state_next = cft_pkg::ST_MUL_STEP;
                end
            end
            cft_pkg::ST_MUL_STEP: begin
                ctl.mul_en = 1'b1;
                state_next = cft_pkg::ST_RAMP;
            end
            cft_pkg::ST_RAMP: begin
                ctl.mul_en = 1'b1;
                state_next = cft_pkg::ST_MUL_DYN;
            end
            cft_pkg::ST_MUL_DYN: begin
                ctl.mul_en = 1'b1;
                state_next = cft_pkg::ST_COEFF;
            end
            cft_pkg::ST_COEFF: begin
                ctl.mul_en = 1'b1;
                state_next = cft_pkg::ST_MUL_CAP;
            end
            cft_pkg::ST_MUL_CAP: begin
                ctl.mul_en = 1'b1;
                state_next = cft_pkg::ST_MUL_TRQ;
            end
            cft_pkg::ST_MUL_TRQ: begin
                ctl.mul_en = 1'b1;
                state_next = cft_pkg::ST_MUL_ACC;
            end
            cft_pkg::ST_MUL_ACC: begin
                ctl.mul_en = 1'b1;
                state_next = cft_pkg::ST_MUL_CHG;
            end
            cft_pkg::ST_MUL_CHG: begin
                ctl.mul_en = 1'b1;
                state_next = cft_pkg::ST_FINISH;
            end
            cft_pkg::ST_FINISH: begin
                // hold here until the output register can take the word
                ctl.finish = out_free;
                if (out_free) begin
                    state_next = cft_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cft_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/clutch_friction_torque_step.sv =====
// clutch friction torque step: one result word per input word, one shared multiplier
// the result is registered from ST_FINISH, which waits while m_ready stalls the output register
// a new word is taken only once the last is done; its eight products share the one multiplier
// s_ready is high only while the sequencer is idle; cfg_ready is always high
// reset (aresetn low, synchronous): registers to defaults, engagement and kept speed to zero
`default_nettype none

module clutch_friction_torque_step (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire cft_pkg::cft_in_t                    s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output cft_pkg::cft_out_t                        m_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [cft_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [cft_pkg::CFG_DATA_W-1:0]      cfg_data
);

    cft_pkg::cft_ctl_t ctl;
    logic              out_free;

    // configuration
    logic [15:0] max_torque_reg;
    logic [15:0] engage_rate_reg;
    logic [15:0] static_fric_reg;
    logic [15:0] dyn_fric_reg;
    logic [23:0] inv_inertia_reg;

    // kept state
    logic [16:0]        eng_reg;
    logic [16:0]        eng_next;
    logic signed [31:0] speed_reg;
    logic signed [31:0] speed_next;

    // per-word working registers
    logic [15:0]        dt_reg;
    logic signed [31:0] speed_in_reg;
    logic [16:0]        tgt_reg;
    logic signed [32:0] slip_reg;
    logic [32:0]        mag_reg;
    logic [16:0]        t_reg;
    logic [16:0]        mf_reg;
    logic               neg_reg;
    logic               slipping_reg;
    logic [31:0]        acc_reg;
    logic [15:0]        coeff_reg;
    logic [30:0]        mtrq_reg;

    logic [32:0] mag_w;
    logic [23:0] ramp_step;
    logic [24:0] eng_up;
    logic [16:0] eng_gap;
    logic [31:0] coeff_sum;

    logic [cft_pkg::MUL_A_W-1:0] mul_a;
    logic [cft_pkg::MUL_B_W-1:0] mul_b;
    logic [cft_pkg::MUL_P_W-1:0] prod;

    logic [38:0]        change;
    logic               lock;
    logic signed [40:0] chg_ext;
    logic signed [40:0] sum_w;
    logic signed [31:0] sum_sat;
    logic signed [31:0] torque_w;

    cft_pkg::cft_out_t m_data_reg;
    cft_pkg::cft_out_t m_data_next;
    logic              m_valid_reg;
    logic              m_valid_next;

    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;

    cft_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .out_free (out_free),
        .s_ready  (s_ready),
        .ctl      (ctl)
    );

    cft_mul u_mul (
        .aclk (aclk),
        .en   (ctl.mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .p    (prod)
    );

    // operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (ctl.state)
            cft_pkg::ST_MUL_STEP: begin
                mul_a = cft_pkg::MUL_A_W'(engage_rate_reg);
                mul_b = cft_pkg::MUL_B_W'(dt_reg);
            end
            cft_pkg::ST_RAMP: begin
                mul_a = cft_pkg::MUL_A_W'(static_fric_reg);
                mul_b = cft_pkg::MUL_B_W'(cft_pkg::UNIT_SLIP - t_reg);
            end
            cft_pkg::ST_MUL_DYN: begin
                mul_a = cft_pkg::MUL_A_W'(dyn_fric_reg);
                mul_b = cft_pkg::MUL_B_W'(t_reg);
            end
            cft_pkg::ST_COEFF: begin
                mul_a = cft_pkg::MUL_A_W'(max_torque_reg);
                mul_b = cft_pkg::MUL_B_W'(eng_reg);
            end
            cft_pkg::ST_MUL_CAP: begin
                // max torque times engagement, times the blended coefficient
                mul_a = cft_pkg::MUL_A_W'(prod[31:0]);
                mul_b = cft_pkg::MUL_B_W'(coeff_reg);
            end
            cft_pkg::ST_MUL_TRQ: begin
                mul_a = cft_pkg::MUL_A_W'(prod[47:18]);
                mul_b = cft_pkg::MUL_B_W'(mf_reg);
            end
            cft_pkg::ST_MUL_ACC: begin
                mul_a = cft_pkg::MUL_A_W'(prod[46:16]);
                mul_b = inv_inertia_reg;
            end
            cft_pkg::ST_MUL_CHG: begin
                mul_a = prod[54:16];
                mul_b = cft_pkg::MUL_B_W'(dt_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mag_w = slip_reg[32] ? 33'(-slip_reg) : 33'(slip_reg);

    // engagement ramp without overshoot
    assign ramp_step = prod[31:8];
    assign eng_up    = 25'(eng_reg) + 25'(ramp_step);
    assign eng_gap   = eng_reg - tgt_reg;

    always_comb begin
        eng_next = eng_reg;
        if (eng_reg < tgt_reg) begin
            eng_next = (eng_up > 25'(tgt_reg)) ? tgt_reg : eng_up[16:0];
        end else if (eng_reg > tgt_reg) begin
            eng_next = (ramp_step >= 24'(eng_gap)) ? tgt_reg : 17'(eng_reg - ramp_step[16:0]);
        end
    end

    assign coeff_sum = acc_reg + prod[31:0];

    // speed update from the last product
    assign change  = prod[54:16];
    assign lock    = (mag_reg < cft_pkg::LOCK_WINDOW) && (change > 39'(mag_reg));
    assign chg_ext = {2'b00, change};
    assign sum_w   = {{9{speed_reg[31]}}, speed_reg} + (neg_reg ? -chg_ext : chg_ext);

    always_comb begin
        if (sum_w[40:31] == '0 || sum_w[40:31] == '1) begin
            sum_sat = sum_w[31:0];
        end else if (sum_w[40]) begin
            sum_sat = 32'sh8000_0000;
        end else begin
            sum_sat = 32'sh7fff_ffff;
        end
    end

    assign torque_w = neg_reg ? -$signed({1'b0, mtrq_reg}) : $signed({1'b0, mtrq_reg});

    always_comb begin
        speed_next                  = speed_reg;
        m_data_next.torque          = torque_w;
        if (inv_inertia_reg != '0) begin
            if (lock) begin
                speed_next         = speed_in_reg;
                m_data_next.torque = '0;
            end else begin
                speed_next = sum_sat;
            end
        end
        m_data_next.shaft_speed_out = speed_next;
        m_data_next.engagement_now  = eng_reg;
        m_data_next.slipping        = slipping_reg;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctl.finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control and kept state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_torque_reg  <= cft_pkg::RST_MAX_TORQUE;
            engage_rate_reg <= cft_pkg::RST_ENGAGE_RATE;
            static_fric_reg <= cft_pkg::RST_STATIC_FRIC;
            dyn_fric_reg    <= cft_pkg::RST_DYN_FRIC;
            inv_inertia_reg <= cft_pkg::RST_INV_INERTIA;
            eng_reg         <= '0;
            speed_reg       <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    cft_pkg::CFG_MAX_TORQUE:  max_torque_reg  <= cfg_data[15:0];
                    cft_pkg::CFG_ENGAGE_RATE: engage_rate_reg <= cfg_data[15:0];
                    cft_pkg::CFG_STATIC_FRIC: static_fric_reg <= cfg_data[15:0];
                    cft_pkg::CFG_DYN_FRIC:    dyn_fric_reg    <= cfg_data[15:0];
                    cft_pkg::CFG_INV_INERTIA: inv_inertia_reg <= cfg_data[23:0];
                    default: ;
                endcase
            end
            if (ctl.state == cft_pkg::ST_RAMP) begin
                eng_reg <= eng_next;
            end
            if (ctl.finish) begin
                speed_reg <= speed_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            dt_reg       <= s_data.time_step;
            speed_in_reg <= s_data.shaft_speed_in;
            tgt_reg      <= (s_data.target_engagement > cft_pkg::FULL_ENGAGE) ?
                            cft_pkg::FULL_ENGAGE : s_data.target_engagement;
            slip_reg     <= {s_data.shaft_speed_in[31], s_data.shaft_speed_in} -
                            {speed_reg[31], speed_reg};
        end
        if (ctl.state == cft_pkg::ST_MUL_STEP) begin
            mag_reg      <= mag_w;
            t_reg        <= (mag_w > 33'(cft_pkg::UNIT_SLIP)) ? cft_pkg::UNIT_SLIP : mag_w[16:0];
            // slip factor is twice the slip, clamped at one
            mf_reg       <= (mag_w >= cft_pkg::LOCK_WINDOW) ? cft_pkg::UNIT_SLIP
                                                              : {mag_w[15:0], 1'b0};
            neg_reg      <= slip_reg[32];
            slipping_reg <= mag_w > cft_pkg::SLIP_LIMIT;
        end
        if (ctl.state == cft_pkg::ST_MUL_DYN) begin
            acc_reg <= prod[31:0];
        end
        if (ctl.state == cft_pkg::ST_COEFF) begin
            coeff_reg <= coeff_sum[31:16];
        end
        if (ctl.state == cft_pkg::ST_MUL_ACC) begin
            mtrq_reg <= prod[46:16];
        end
        if (ctl.finish) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== sv/cft_checker.sv =====
// port-level checks for the clutch friction torque step, bound to the top level
`default_nettype none

`include "clutch_friction_torque_step_macros.svh"

module cft_checker (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire cft_pkg::cft_out_t m_data
);

    // a stalled result word holds
    `CFT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // one word at a time: busy right after taking a word
    `CFT_ASSERT_NEXT(a_busy_after_take, aclk, aresetn, s_valid && s_ready, !s_ready)

    // no result can appear the cycle after a word is taken
    `CFT_ASSERT_NEXT(a_no_early_result, aclk, aresetn, s_valid && s_ready, !$rose(m_valid))

    `CFT_ASSERT_IMP(a_engage_range, aclk, aresetn, m_valid, m_data.engagement_now <= 17'h10000)

endmodule

bind clutch_friction_torque_step cft_checker u_cft_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
